// ===== sv/plvs_pkg.sv =====
// Shared types and constants for the priority-aware LRU victim selector.
// No dependencies; used by the slot cell and the top level.
`timescale 1ns / 1ps

package plvs_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int STAMP_W    = 32;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_TOUCH  = 2'd1,
        ACT_SELECT = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    localparam logic [1:0] PRESSURE_HIGH = 2'd1;
    localparam logic [2:0] PRIO_NONE     = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] slot;
        logic       incoming_present;
        logic       pressure_evict;
        logic       evict;
        logic       allocated;
        logic       pinned;
        logic       attempted;
        logic       hot;
        logic [2:0] priority_req;
        logic       valid_req;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [4:0] victim_slot;
    } rsp_t;

    // Metadata of one slot as it travels along the ring
    typedef struct packed {
        logic               allocated;
        logic               pinned;
        logic               attempted;
        logic               hot;
        logic [2:0]         prio;
        logic               valid;
        logic [STAMP_W-1:0] last_use;
    } meta_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic              shift;
        logic              wr;
        logic              touch;
        logic              evict;
        logic [SLOT_W-1:0] slot;
        meta_t             wdata;
        logic [STAMP_W-1:0] stamp;
    } cell_ctl_t;

endpackage

// ===== sv/priority_lru_victim_selector.sv =====
// Top level of the priority-aware LRU victim selector: control, compare, APB register.
// Depends on plvs_pkg and plvs_cell.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive req and pulse start while busy is low; the
//   transaction is taken at that edge. busy stays high until the result.
//   Result channel: done is high for exactly one cycle, with rsp valid.
//   Write and touch: the entry updates as start is taken, then the done state registers done.
//   Select: the slot ring rotates once past a compare stage, one slot per
//   cycle, then the done state registers done and rsp. Eviction clears the
//   victim on the done edge.
//   APB: pressure_level at address 0, written with psel/penable/pwrite;
//   pready is always high. Write it only while busy is low.
//   Reset: all slots unallocated, priority 4, stamps and use clock zero,
//   pressure_level zero. The receiver cannot stall: done is a strobe.
module priority_lru_victim_selector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  plvs_pkg::req_t    req,
    output logic              busy,
    output logic              done,
    output plvs_pkg::rsp_t    rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int N = plvs_pkg::SLOT_COUNT;
    localparam int SW = plvs_pkg::SLOT_W;

    plvs_pkg::state_t     state_reg, state_next;
    plvs_pkg::req_t       req_reg;
    logic [1:0]           pressure_reg;
    logic [31:0]          clock_reg, clock_next;
    logic [plvs_pkg::CNT_W-1:0] cnt_reg;
    logic [SW-1:0]        pos_reg;
    logic                 have_reg;
    logic [SW-1:0]        best_reg;
    plvs_pkg::meta_t      bmeta_reg;
    plvs_pkg::meta_t      inc_meta_reg;
    logic                 evict_pend_reg;
    plvs_pkg::rsp_t       rsp_reg;
    logic                 done_reg;
    plvs_pkg::cell_ctl_t  ctl;
    plvs_pkg::meta_t      ring [N];
    plvs_pkg::meta_t      cur;
    logic                 accept, in_range, has_inc, elig, beats, scan_last;
    logic                 evict_now;

    assign pready  = 1'b1;
    assign prdata  = {30'd0, pressure_reg};
    assign busy    = (state_reg != plvs_pkg::ST_IDLE);
    assign done    = done_reg;
    assign rsp     = rsp_reg;
    assign accept  = start && !busy;
    assign in_range = ({1'b0, req_reg.slot} < (6)'(N));
    assign has_inc = req_reg.incoming_present && in_range;
    assign cur     = ring[0];
    assign scan_last = (cnt_reg == (plvs_pkg::CNT_W)'(N - 1));

    // Clear the victim while the ring is at rest and no new transaction can enter
    assign evict_now = (state_reg == plvs_pkg::ST_DONE) && have_reg && req_reg.evict &&
                       req_reg.action == plvs_pkg::ACT_SELECT;

    // Slot ring: cell i passes toward cell i-1, cell 0 wraps to the top
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        plvs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   ((SW)'(i)),
            .ctl     (ctl),
            .meta_in (ring[(i + 1) % N]),
            .meta_out(ring[i])
        );
    end

    // Eligibility of the slot now in cell 0 (original index pos_reg)
    always_comb
    begin
        elig = cur.allocated && !cur.pinned && !cur.attempted;
        if (has_inc && pos_reg == req_reg.slot[SW-1:0])
            elig = 1'b0;
        if (req_reg.pressure_evict && pressure_reg == plvs_pkg::PRESSURE_HIGH
            && (cur.hot || cur.prio == 3'd0))
            elig = 1'b0;
        if (!req_reg.pressure_evict && has_inc && inc_meta_reg.prio != 3'd0 && cur.valid
            && (cur.hot || cur.prio <= inc_meta_reg.prio))
            elig = 1'b0;
    end

    // Ordering against the best so far
    always_comb
    begin
        priority if (cur.valid != bmeta_reg.valid)
            beats = !cur.valid;
        else if (cur.hot != bmeta_reg.hot)
            beats = !cur.hot;
        else if (cur.prio != bmeta_reg.prio)
            beats = cur.prio > bmeta_reg.prio;
        else
            beats = cur.last_use < bmeta_reg.last_use;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plvs_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (req.action == plvs_pkg::ACT_SELECT) ?
                                 plvs_pkg::ST_SCAN : plvs_pkg::ST_DONE;
            end
            plvs_pkg::ST_SCAN:
            begin
                if (scan_last)
                    state_next = plvs_pkg::ST_DONE;
            end
            plvs_pkg::ST_DONE: state_next = plvs_pkg::ST_IDLE;
            default:           state_next = plvs_pkg::ST_IDLE;
        endcase
    end

    // Cell control outputs
    always_comb
    begin
        clock_next = (clock_reg == 32'hFFFF_FFFF) ? clock_reg : clock_reg + 32'd1;
        ctl.shift = (state_reg == plvs_pkg::ST_SCAN);
        ctl.wr    = accept && req.action == plvs_pkg::ACT_WRITE;
        ctl.touch = accept && req.action == plvs_pkg::ACT_TOUCH;
        ctl.evict = evict_now;
        ctl.slot  = evict_now ? best_reg : req.slot[SW-1:0];
        if (!evict_now && ({1'b0, req.slot} >= (6)'(N)))
        begin
            ctl.wr    = 1'b0;
            ctl.touch = 1'b0;
        end
        ctl.wdata = '{allocated: req.allocated, pinned: req.pinned,
                      attempted: req.attempted, hot: req.hot,
                      prio: req.priority_req, valid: req.valid_req, last_use: '0};
        ctl.stamp = clock_next;
    end

    // Datapath and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= plvs_pkg::ST_IDLE;
            pressure_reg   <= 2'd0;
            clock_reg      <= '0;
            done_reg       <= 1'b0;
            evict_pend_reg <= 1'b0;
            have_reg       <= 1'b0;
            cnt_reg        <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= 1'b0;
            evict_pend_reg <= 1'b0;
            if (psel && penable && pwrite && paddr == 2'd0)
                pressure_reg <= pwdata[1:0];
            if (ctl.touch)
                clock_reg <= clock_next;
            if (accept)
            begin
                have_reg <= 1'b0;
                cnt_reg  <= '0;
                pos_reg  <= '0;
            end
            if (state_reg == plvs_pkg::ST_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                pos_reg <= pos_reg + 1'b1;
                if (elig && (!have_reg || beats))
                    have_reg <= 1'b1;
            end
            if (state_reg == plvs_pkg::ST_DONE)
            begin
                done_reg       <= 1'b1;
                evict_pend_reg <= evict_now;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
            inc_meta_reg <= ring[req.slot[SW-1:0]];
        end
        if (state_reg == plvs_pkg::ST_SCAN && elig && (!have_reg || beats))
        begin
            best_reg  <= pos_reg;
            bmeta_reg <= cur;
        end
        if (state_reg == plvs_pkg::ST_DONE)
        begin
            rsp_reg.found       <= have_reg && req_reg.action == plvs_pkg::ACT_SELECT;
            rsp_reg.victim_slot <= (have_reg && req_reg.action == plvs_pkg::ACT_SELECT) ?
                                   5'(best_reg) : 5'd0;
        end
    end

    // A scan ends with the ring back in place, so busy covers a full rotation
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plvs_pkg::ST_SCAN && scan_last) |=> state_reg == plvs_pkg::ST_DONE)
        else $error("scan length mismatch");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == plvs_pkg::ST_IDLE)
        else $error("done outside idle");
    a_evict_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        evict_pend_reg |-> done_reg && rsp_reg.found)
        else $error("eviction without a found victim");

endmodule

// ===== sv/plvs_cell.sv =====
// One slot cell: holds one slot's metadata and hands it to its neighbor on shift.
// Depends on plvs_pkg.
`timescale 1ns / 1ps

module plvs_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [plvs_pkg::SLOT_W-1:0] index,
    input  plvs_pkg::cell_ctl_t       ctl,
    input  plvs_pkg::meta_t           meta_in,
    output plvs_pkg::meta_t           meta_out
);

    plvs_pkg::meta_t meta_reg;
    plvs_pkg::meta_t meta_next;
    logic            hit;

    assign hit      = (ctl.slot == index);
    assign meta_out = meta_reg;

    // Shift during a scan, otherwise update the addressed entry
    always_comb
    begin
        meta_next = meta_reg;
        if (ctl.shift)
        begin
            meta_next = meta_in;
        end
        else if (hit && ctl.wr)
        begin
            meta_next = ctl.wdata;
            meta_next.last_use = meta_reg.last_use;
        end
        else if (hit && ctl.touch)
        begin
            meta_next.last_use = ctl.stamp;
            meta_next.prio     = 3'd0;
        end
        else if (hit && ctl.evict)
        begin
            meta_next.allocated = 1'b0;
            meta_next.valid     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_reg <= '{allocated: 1'b0, pinned: 1'b0, attempted: 1'b0, hot: 1'b0,
                          prio: plvs_pkg::PRIO_NONE, valid: 1'b0, last_use: '0};
        end
        else
        begin
            meta_reg <= meta_next;
        end
    end

endmodule
